// File: rtl/ced_pkg.sv
// Shared types, character codes and digit decode for the C escape decoder.
package ced_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    ModeNormal = 2'd0,
    ModeBslash = 2'd1,
    ModeHex    = 2'd2,
    ModeOctal  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       bad_escape;
  } result_t;

  // Up to two results per input transfer; first always goes ahead of second in the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

  localparam logic [7:0] CharBslash = 8'h5C;
  localparam logic [7:0] CharDquote = 8'h22;
  localparam logic [7:0] CharSquote = 8'h27;
  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharNine   = 8'h39;
  localparam logic [7:0] CharSeven  = 8'h37;
  localparam logic [7:0] CharLowA   = 8'h61;
  localparam logic [7:0] CharLowB   = 8'h62;
  localparam logic [7:0] CharLowF   = 8'h66;
  localparam logic [7:0] CharLowN   = 8'h6E;
  localparam logic [7:0] CharLowR   = 8'h72;
  localparam logic [7:0] CharLowT   = 8'h74;
  localparam logic [7:0] CharLowV   = 8'h76;
  localparam logic [7:0] CharLowX   = 8'h78;
  localparam logic [7:0] CharUpA    = 8'h41;
  localparam logic [7:0] CharUpF    = 8'h46;
  localparam logic [7:0] CharUpX    = 8'h58;

  localparam logic [7:0] LowerBase  = CharLowA - 8'd10;
  localparam logic [7:0] UpperBase  = CharUpA - 8'd10;

  localparam logic [7:0] CtrlBell   = 8'd7;
  localparam logic [7:0] CtrlBack   = 8'd8;
  localparam logic [7:0] CtrlTab    = 8'd9;
  localparam logic [7:0] CtrlNewl   = 8'd10;
  localparam logic [7:0] CtrlVtab   = 8'd11;
  localparam logic [7:0] CtrlFeed   = 8'd12;
  localparam logic [7:0] CtrlCret   = 8'd13;

  localparam logic [1:0] OctalMaxDigits = 2'd3;

  // {valid, value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CharZero && c <= CharNine) begin
      r = {1'b1, 4'(c - CharZero)};
    end else if (c >= CharLowA && c <= CharLowF) begin
      r = {1'b1, 4'(c - LowerBase)};
    end else if (c >= CharUpA && c <= CharUpF) begin
      r = {1'b1, 4'(c - UpperBase)};
    end
    return r;
  endfunction

  function automatic logic [3:0] oct_digit(input logic [7:0] c);
    logic [3:0] r;
    r = '0;
    if (c >= CharZero && c <= CharSeven) begin
      r = {1'b1, c[2:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/ced_front.sv
// Front end: takes characters, tracks escape mode and produces up to two results.
module ced_front
  import ced_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_char_i,
  input  logic       end_of_string_i,
  output push_t      push_o
);

  mode_e      mode_q, mode_d;
  logic [7:0] acc_q, acc_d;
  logic [1:0] cnt_q, cnt_d;

  logic       accept;
  logic [4:0] hex_d;
  logic [3:0] oct_d;
  logic [7:0] hex_acc, oct_acc;
  logic [1:0] cnt_inc;
  logic       goes_escape;

  assign accept      = in_valid_i & in_ready_i;
  assign hex_d       = hex_digit(in_char_i);
  assign oct_d       = oct_digit(in_char_i);
  assign hex_acc     = {acc_q[3:0], hex_d[3:0]};
  assign oct_acc     = {acc_q[4:0], oct_d[2:0]};
  assign cnt_inc     = cnt_q + 2'd1;
  assign goes_escape = (in_char_i == CharBslash) & ~end_of_string_i;

  // next state
  always_comb begin
    mode_d = mode_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    if (accept) begin
      case (mode_q)
        ModeNormal: begin
          if (goes_escape) mode_d = ModeBslash;
        end
        ModeBslash: begin
          if (in_char_i == CharLowX || in_char_i == CharUpX) begin
            mode_d = ModeHex;
            acc_d  = '0;
          end else if (in_char_i == CharZero) begin
            mode_d = ModeOctal;
            acc_d  = '0;
            cnt_d  = '0;
          end else begin
            mode_d = ModeNormal;
          end
        end
        ModeHex: begin
          if (hex_d[4]) begin
            acc_d = hex_acc;
          end else begin
            mode_d = goes_escape ? ModeBslash : ModeNormal;
          end
        end
        ModeOctal: begin
          if (oct_d[3]) begin
            acc_d = oct_acc;
            cnt_d = cnt_inc;
            if (end_of_string_i || cnt_inc == OctalMaxDigits) mode_d = ModeNormal;
          end else begin
            mode_d = goes_escape ? ModeBslash : ModeNormal;
          end
        end
        default: mode_d = ModeNormal;
      endcase
      if (end_of_string_i) begin
        mode_d = ModeNormal;
        acc_d  = '0;
        cnt_d  = '0;
      end else if (mode_d == ModeNormal) begin
        acc_d = '0;
        cnt_d = '0;
      end
    end
  end

  // results
  always_comb begin
    push_o = '0;
    if (accept) begin
      case (mode_q)
        ModeNormal: begin
          if (!goes_escape) begin
            push_o.count = 2'd1;
            push_o.first = '{in_char_i, end_of_string_i, 1'b0};
          end
        end
        ModeBslash: begin
          push_o.count = 2'd1;
          case (in_char_i)
            CharDquote: push_o.first = '{CharDquote, end_of_string_i, 1'b0};
            CharSquote: push_o.first = '{CharSquote, end_of_string_i, 1'b0};
            CharBslash: push_o.first = '{CharBslash, end_of_string_i, 1'b0};
            CharLowA:   push_o.first = '{CtrlBell,   end_of_string_i, 1'b0};
            CharLowB:   push_o.first = '{CtrlBack,   end_of_string_i, 1'b0};
            CharLowF:   push_o.first = '{CtrlFeed,   end_of_string_i, 1'b0};
            CharLowN:   push_o.first = '{CtrlNewl,   end_of_string_i, 1'b0};
            CharLowR:   push_o.first = '{CtrlCret,   end_of_string_i, 1'b0};
            CharLowT:   push_o.first = '{CtrlTab,    end_of_string_i, 1'b0};
            CharLowV:   push_o.first = '{CtrlVtab,   end_of_string_i, 1'b0};
            CharLowX, CharUpX, CharZero: begin
              // numeric escape opens; only an end of string flushes a zero
              push_o.count = {1'b0, end_of_string_i};
              push_o.first = '{8'd0, 1'b1, 1'b0};
            end
            default:    push_o.first = '{8'd0, end_of_string_i, 1'b1};
          endcase
        end
        ModeHex, ModeOctal: begin
          if ((mode_q == ModeHex) ? hex_d[4] : oct_d[3]) begin
            if (mode_q == ModeHex) begin
              push_o.count = {1'b0, end_of_string_i};
              push_o.first = '{hex_acc, 1'b1, 1'b0};
            end else begin
              push_o.count = {1'b0, end_of_string_i | (cnt_inc == OctalMaxDigits)};
              push_o.first = '{oct_acc, end_of_string_i, 1'b0};
            end
          end else begin
            // terminator: flush value, then treat char as normal text
            push_o.first = '{acc_q, 1'b0, 1'b0};
            if (goes_escape) begin
              push_o.count = 2'd1;
            end else begin
              push_o.count  = 2'd2;
              push_o.second = '{in_char_i, end_of_string_i, 1'b0};
            end
          end
        end
        default: push_o = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeNormal;
      acc_q  <= '0;
      cnt_q  <= '0;
    end else begin
      mode_q <= mode_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
    end
  end

`ifndef SYNTH
  a_two_only_numeric: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (mode_q == ModeHex || mode_q == ModeOctal))
    else $error("two results outside a numeric escape");

  a_bad_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count != 2'd0 && push_o.first.bad_escape) |->
      (push_o.first.out_byte == 8'd0 && mode_q == ModeBslash))
    else $error("bad escape result malformed");

  a_eos_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && end_of_string_i) |=> (mode_q == ModeNormal && acc_q == 8'd0 && cnt_q == 2'd0))
    else $error("state not cleared after end of string");
`endif

endmodule

// File: rtl/ced_queue.sv
// Result queue: up to two writes and one read per cycle.
module ced_queue
  import ced_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output logic    space_o,
  output logic    empty_o,
  output result_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  result_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntW-1:0]   cnt_q, cnt_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wr_next = ptr_inc(wr_q);
  assign space_o = cnt_q <= CntW'(Depth - 2);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d = wr_q;
    if (push_i.count == 2'd1) wr_d = wr_next;
    else if (push_i.count == 2'd2) wr_d = ptr_inc(wr_next);
    rd_d  = pop_i ? ptr_inc(rd_q) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wr_next] <= push_i.second;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> space_o)
    else $error("push without room");
`endif

endmodule

// File: rtl/ced_back.sv
// Back end: output register that drains the result queue.
module ced_back
  import ced_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    empty_i,
  input  result_t head_i,
  output logic    pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign pop_o   = ~empty_i & (~valid_q | out_ready_i);
  assign valid_d = pop_o | (valid_q & ~out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) data_q <= head_i;
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule

// File: rtl/c_escape_sequence_decoder_top.sv
// Top level of the C string escape decoder.
// Decodes a C string one source character per transfer and returns the decoded bytes:
// simple escapes (quote, apostrophe, backslash, a b f n r t v), hex escapes (x/X, any
// number of digits) and octal escapes (0 plus up to three digits), values kept to 8 bits.
// An illegal escape letter yields a result with bad_escape set and out_byte zero. A
// character that terminates a numeric escape yields two results: the value, then the
// character itself (a backslash terminator yields only the value and opens a new escape).
// The front end classifies each character in the cycle it is accepted
// and writes its results into a small queue; the back end is the output register. A
// character is taken every cycle while the queue holds at least two free slots; the
// front end stalls only while the queue holds fewer than two free slots, whatever the
// number of results the character makes. The first result of a character is written
// into the queue and then loaded into the output register before it can transfer on
// the output side.
module c_escape_sequence_decoder_top
  import ced_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_char_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o,
  output logic       bad_escape_o
);

  push_t   push;
  logic    space, empty, pop;
  result_t head, out_res;

  assign in_ready_o = space;

  ced_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (space),
    .in_char_i,
    .end_of_string_i,
    .push_o          (push)
  );

  ced_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .pop_i   (pop),
    .space_o (space),
    .empty_o (empty),
    .head_o  (head)
  );

  ced_back u_back (
    .clk_i,
    .rst_ni,
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o,
    .out_ready_i,
    .out_o       (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign last_o       = out_res.last;
  assign bad_escape_o = out_res.bad_escape;

endmodule

// File: tb/tb_c_escape_sequence_decoder_top.sv
// Self-checking testbench for the C string escape decoder top level.
`timescale 1ns / 1ps

module tb_c_escape_sequence_decoder_top;
  import ced_pkg::*;

  // Letters the package does not name; needed for the digit range checks.
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpZ   = 8'h5A;
  localparam int         NumStr  = 1200;  // least number of source characters in the whole run
  localparam int         QuietAt = 1000;  // no idling on either side past this count
  localparam int         MaxShown = 10;

  // One row of the directed table. With typed set, the expected transfers are the ones
  // typed into the row; otherwise they come from the decode model.
  typedef struct packed {
    logic [7:0] ch;
    logic       eos;
    logic       typed;
    logic [1:0] n_res;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  localparam result_t NoRes = '0;
  localparam int      NumRows = 28;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_char = 8'h20;
  logic       in_eos = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;
  logic       bad_escape_o;

  // Decode model state: mirrors the escape mode, the running numeric value and the
  // octal digit count.
  mode_e      esc_mode;
  logic [7:0] esc_value;
  logic [1:0] oct_count;
  result_t    step_res [2];
  int         step_n;

  result_t    decoded_q [$];  // decoded bytes still owed by the block
  int         err_cnt = 0;
  int         chars_sent = 0;
  bit         idle_en = 1'b1;
  bit         src_gaps = 1'b1;
  int         stall_left = 0;
  dir_row_t   dir_tab [NumRows];

  c_escape_sequence_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .in_char_i      (in_char),
    .end_of_string_i(in_eos),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .out_byte_o     (out_byte_o),
    .last_o         (last_o),
    .bad_escape_o   (bad_escape_o)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------------

  // Digit value in the given base, -1 when c is not a digit of that base.
  function automatic int digit_val(input logic [7:0] c, input int base);
    int d;
    if (c >= CharZero && c <= CharNine) d = c - CharZero;
    else if (c >= CharLowA && c <= ChLowZ) d = c - CharLowA + 10;
    else if (c >= CharUpA && c <= ChUpZ) d = c - CharUpA + 10;
    else return -1;
    return (d < base) ? d : -1;
  endfunction

  function automatic bit is_escape_letter(input logic [7:0] c);
    case (c)
      CharDquote, CharSquote, CharBslash, CharLowA, CharLowB, CharLowF, CharLowN,
      CharLowR, CharLowT, CharLowV, CharLowX, CharUpX, CharZero: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic add_res(input logic [7:0] b, input logic lst, input logic bad);
    step_res[step_n] = '{out_byte: b, last: lst, bad_escape: bad};
    step_n++;
  endtask

  // Plain character: a backslash opens an escape unless it ends the string.
  task automatic plain_char(input logic [7:0] c, input logic eos);
    if (c == CharBslash && !eos) esc_mode = ModeBslash;
    else add_res(c, eos, 1'b0);
  endtask

  // Advance the model by one source character; results land in step_res[0:step_n-1].
  task automatic decode_char(input logic [7:0] c, input logic eos);
    int d;
    step_n = 0;
    case (esc_mode)
      ModeNormal: plain_char(c, eos);
      ModeBslash: begin
        esc_mode = ModeNormal;
        case (c)
          CharDquote, CharSquote, CharBslash: add_res(c, eos, 1'b0);
          CharLowA: add_res(CtrlBell, eos, 1'b0);
          CharLowB: add_res(CtrlBack, eos, 1'b0);
          CharLowF: add_res(CtrlFeed, eos, 1'b0);
          CharLowN: add_res(CtrlNewl, eos, 1'b0);
          CharLowR: add_res(CtrlCret, eos, 1'b0);
          CharLowT: add_res(CtrlTab, eos, 1'b0);
          CharLowV: add_res(CtrlVtab, eos, 1'b0);
          CharLowX, CharUpX: begin
            esc_mode  = ModeHex;
            esc_value = '0;
            if (eos) add_res(8'h00, 1'b1, 1'b0);
          end
          CharZero: begin
            esc_mode  = ModeOctal;
            esc_value = '0;
            oct_count = '0;
            if (eos) add_res(8'h00, 1'b1, 1'b0);
          end
          default: add_res(8'h00, eos, 1'b1);
        endcase
      end
      ModeHex: begin
        d = digit_val(c, 16);
        if (d >= 0) begin
          esc_value = {esc_value[3:0], 4'(d)};
          if (eos) add_res(esc_value, 1'b1, 1'b0);
        end else begin
          // terminator: value first, then the character on its own
          add_res(esc_value, 1'b0, 1'b0);
          esc_mode = ModeNormal;
          plain_char(c, eos);
        end
      end
      default: begin
        d = digit_val(c, 8);
        if (d >= 0) begin
          esc_value = {esc_value[4:0], 3'(d)};
          oct_count = oct_count + 2'd1;
          if (eos || oct_count >= OctalMaxDigits) begin
            add_res(esc_value, eos, 1'b0);
            esc_mode  = ModeNormal;
            esc_value = '0;
            oct_count = '0;
          end
        end else begin
          add_res(esc_value, 1'b0, 1'b0);
          esc_mode = ModeNormal;
          plain_char(c, eos);
        end
      end
    endcase
    if (eos) esc_mode = ModeNormal;
    if (esc_mode == ModeNormal) begin
      esc_value = '0;
      oct_count = '0;
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------------

  // Present one character, wait for its transfer, then log what it must produce.
  // Inputs move only at the falling edge; the handshake is seen at the rising edge.
  task automatic send_char(input dir_row_t row);
    int gap;
    gap = 0;
    if (idle_en && src_gaps && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_char  <= row.ch;
    in_eos   <= row.eos;
    do @(posedge clk_i); while (!in_ready_o);
    decode_char(row.ch, row.eos);
    if (row.typed) begin
      if (row.n_res >= 2'd1) decoded_q.push_back(row.r0);
      if (row.n_res >= 2'd2) decoded_q.push_back(row.r1);
    end else begin
      for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
    end
    chars_sent++;
  endtask

  function automatic dir_row_t mk_row(input logic [7:0] ch, input logic eos,
                                      input logic typed = 1'b0, input int n = 0,
                                      input result_t r0 = NoRes, input result_t r1 = NoRes);
    dir_row_t r;
    r = '{ch: ch, eos: eos, typed: typed, n_res: 2'(n), r0: r0, r1: r1};
    return r;
  endfunction

  // Random string body: mostly well-formed escape tokens with random content.
  logic [7:0] str_q [$];

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (c == CharBslash);
    return c;
  endfunction

  task automatic build_string();
    string      hex_set;
    logic [7:0] simple_set [10];
    logic [7:0] c;
    int         n_tok;
    hex_set    = "0123456789abcdefABCDEF";
    simple_set = '{CharDquote, CharSquote, CharBslash, CharLowA, CharLowB,
                   CharLowF, CharLowN, CharLowR, CharLowT, CharLowV};
    str_q.delete();
    n_tok = $urandom_range(1, 6);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 9))
        0, 1: str_q.push_back(rand_plain());
        2, 3: begin
          str_q.push_back(CharBslash);
          str_q.push_back(simple_set[$urandom_range(0, 9)]);
        end
        4, 5: begin
          str_q.push_back(CharBslash);
          str_q.push_back($urandom_range(0, 1) ? CharLowX : CharUpX);
          repeat ($urandom_range(0, 4)) str_q.push_back(hex_set[$urandom_range(0, 21)]);
        end
        6, 7: begin
          str_q.push_back(CharBslash);
          str_q.push_back(CharZero);
          repeat ($urandom_range(0, 3)) str_q.push_back(8'(CharZero + $urandom_range(0, 7)));
        end
        8: begin
          // illegal escape letter
          do c = 8'($urandom_range(1, 255)); while (is_escape_letter(c));
          str_q.push_back(CharBslash);
          str_q.push_back(c);
        end
        default: str_q.push_back(8'($urandom_range(1, 255)));  // raw noise
      endcase
    end
    // Now and then leave a lone backslash as the final character.
    if ($urandom_range(0, 9) == 0) str_q.push_back(CharBslash);
  endtask

  // ---------------------------------------------------------------------------------
  // Sink side
  // ---------------------------------------------------------------------------------

  // Ready drops in random bursts while idling is on.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every output transfer is matched against the oldest outstanding decoded byte.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (decoded_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxShown)
          $display("MISMATCH t=%0t: unexpected transfer byte=%h last=%b bad=%b",
                   $time, out_byte_o, last_o, bad_escape_o);
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.out_byte || last_o !== want.last ||
            bad_escape_o !== want.bad_escape) begin
          err_cnt++;
          if (err_cnt <= MaxShown)
            $display("MISMATCH t=%0t: exp byte=%h last=%b bad=%b, got byte=%h last=%b bad=%b",
                     $time, want.out_byte, want.last, want.bad_escape,
                     out_byte_o, last_o, bad_escape_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------------
  initial begin
    esc_mode  = ModeNormal;
    esc_value = '0;
    oct_count = '0;

    // Directed table. Rows with typed results cover the state right after reset, the
    // character extremes, illegal escapes and the end-of-string corner cases.
    dir_tab[0]  = mk_row("A", 1'b0, 1'b1, 1, '{"A", 1'b0, 1'b0});
    dir_tab[1]  = mk_row(8'hFF, 1'b0, 1'b1, 1, '{8'hFF, 1'b0, 1'b0});
    dir_tab[2]  = mk_row(8'h01, 1'b0, 1'b1, 1, '{8'h01, 1'b0, 1'b0});
    dir_tab[3]  = mk_row(CharBslash, 1'b0, 1'b1, 0);
    dir_tab[4]  = mk_row("q", 1'b0, 1'b1, 1, '{8'h00, 1'b0, 1'b1});
    dir_tab[5]  = mk_row(CharBslash, 1'b0);
    dir_tab[6]  = mk_row(CharLowN, 1'b0);
    dir_tab[7]  = mk_row(CharBslash, 1'b0);
    dir_tab[8]  = mk_row(CharDquote, 1'b0);
    // hex escape past 8 bits, ended by a non-digit: value, then the letter itself
    dir_tab[9]  = mk_row(CharBslash, 1'b0);
    dir_tab[10] = mk_row(CharLowX, 1'b0);
    dir_tab[11] = mk_row(CharLowF, 1'b0);
    dir_tab[12] = mk_row(CharUpF, 1'b0);
    dir_tab[13] = mk_row("1", 1'b0);
    dir_tab[14] = mk_row("g", 1'b0);
    // octal escape closed by its third digit
    dir_tab[15] = mk_row(CharBslash, 1'b0);
    dir_tab[16] = mk_row(CharZero, 1'b0);
    dir_tab[17] = mk_row(CharSeven, 1'b0);
    dir_tab[18] = mk_row(CharSeven, 1'b0);
    dir_tab[19] = mk_row(CharSeven, 1'b0);
    // octal escape ended by 8, which is not an octal digit
    dir_tab[20] = mk_row(CharBslash, 1'b0);
    dir_tab[21] = mk_row(CharZero, 1'b0);
    dir_tab[22] = mk_row("8", 1'b0);
    // hex escape opened on the final character
    dir_tab[23] = mk_row(CharBslash, 1'b0);
    dir_tab[24] = mk_row(CharUpX, 1'b1, 1'b1, 1, '{8'h00, 1'b1, 1'b0});
    // lone trailing backslash is passed through
    dir_tab[25] = mk_row(CharBslash, 1'b1, 1'b1, 1, '{CharBslash, 1'b1, 1'b0});
    // illegal letter on the final character
    dir_tab[26] = mk_row(CharBslash, 1'b0, 1'b1, 0);
    dir_tab[27] = mk_row("Q", 1'b1, 1'b1, 1, '{8'h00, 1'b1, 1'b1});

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_tab[i]) send_char(dir_tab[i]);

    // Random strings; the final stretch runs with no idling on either side.
    while (chars_sent < NumStr) begin
      build_string();
      src_gaps = ($urandom_range(0, 3) != 0);
      foreach (str_q[i]) begin
        if (chars_sent >= QuietAt) idle_en = 1'b0;
        send_char(mk_row(str_q[i], i == str_q.size() - 1));
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;

    // Drain, then keep clocking the pipeline to show any stray transfer.
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
